// ===== hdl/sps_pkg.sv =====
package sps_pkg;

  localparam int NODE_W          = 6;
  localparam int SLOTS           = 64;
  localparam int CNT_W           = 7;
  localparam int DIST_W          = 22;
  localparam int EDGE_DEPTH      = SLOTS * SLOTS;
  localparam int MAX_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int IN_WEIGHT_W     = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [NODE_W:0]   NO_PRED  = {1'b1, {NODE_W{1'b0}}};

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// ===== hdl/sps_if.sv =====
interface sps_req_if;
  import sps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [NODE_W-1:0]      from_node;
  logic [NODE_W-1:0]      to_node;
  logic [IN_WEIGHT_W-1:0] edge_weight;
  logic                   edge_present;
  modport source (output valid, command, from_node, to_node, edge_weight, edge_present,
                  input ready);
  modport sink   (input valid, command, from_node, to_node, edge_weight, edge_present,
                  output ready);
endinterface

interface sps_rsp_if;
  import sps_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] path_node;
  logic              path_found;
  logic [DIST_W-1:0] total_distance;
  logic              last;
  modport source (output valid, path_node, path_found, total_distance, last, input ready);
  modport sink   (input valid, path_node, path_found, total_distance, last, output ready);
endinterface

interface sps_cfg_if;
  import sps_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/sps_ram.sv =====
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule

// ===== hdl/single_pair_shortest_path.sv =====
// Edge write: accepted, no result. Query: per settled node a scan over the active nodes, a
// decision state and a relax of that node's edge row (n = active node count), then a trace step
// (S_TRD, S_TWT) per path node and a read and load step (S_ERD, S_ELD) per result to emit.
// Throughput: one transaction at a time; the scan/relax sequencer over the memories sets it.
// Reset: synchronous; a clearing pass over every edge slot marks each edge absent, no request
// is taken during it. Configuration writes are taken at any time.
module single_pair_shortest_path #(
  parameter int MAX_NODES   = sps_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = sps_pkg::WEIGHT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sps_req_if.sink   req,
  sps_rsp_if.source rsp,
  sps_cfg_if.sink   cfg
);
  import sps_pkg::*;

  localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
  localparam int EDGE_W = WEIGHT_BITS + 1;
  localparam int EA_W = $clog2(EDGE_DEPTH);
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_RELAX = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_TWT   = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_ELD   = 4'd8;
  localparam logic [3:0] S_NF    = 4'd9;

  logic [3:0]        state;
  logic [EA_W-1:0]   clr;
  logic [CNT_W-1:0]  node_count;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  i;
  logic              p_v;
  logic [NODE_W-1:0] p_i;
  logic              have;
  logic [NODE_W-1:0] q;
  logic [DIST_W-1:0] qdist;
  logic [DIST_W-1:0] res_dist;
  logic [SLOTS-1:0]  reached;
  logic [SLOTS-1:0]  visited;
  logic [NODE_W-1:0] dst;
  logic [NODE_W-1:0] x;
  logic [CNT_W-1:0]  cnt;
  logic [NODE_W-1:0] idx;

  // memory ports
  logic              e_we;
  logic [EA_W-1:0]   e_wa;
  logic [EDGE_W-1:0] e_wd, e_rd;
  logic              d_we;
  logic [NODE_W-1:0] d_wa;
  logic [DIST_W-1:0] d_wd, d_rd;
  logic              p_we;
  logic [NODE_W-1:0] p_wa;
  logic [NODE_W:0]   p_wd, p_rd;
  logic              b_we;
  logic [NODE_W-1:0] b_rd;

  logic                   accept;
  logic                   query_ok;
  logic [WEIGHT_BITS-1:0] in_w;
  logic [SUM_W-1:0]       alt_sum;
  logic [DIST_W-1:0]      alt;
  logic                   relax_hit;
  logic                   scan_hit;
  logic                   out_free;
  logic                   emit;
  logic                   sweep_done;

  assign n = (node_count < MAX_N) ? node_count : MAX_N;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept = req.valid && req.ready;
  assign query_ok = ({1'b0, req.from_node} < n) && ({1'b0, req.to_node} < n);
  assign in_w = WEIGHT_BITS'(req.edge_weight);
  assign out_free = !rsp.valid || rsp.ready;
  // load a result transaction this cycle
  assign emit = out_free && (state == S_ELD || state == S_NF);
  assign sweep_done = (i == n) && !p_v;

  // relax arithmetic: saturate the candidate distance
  assign alt_sum = SUM_W'(qdist) + SUM_W'(e_rd[WEIGHT_BITS-1:0]);
  assign alt = (alt_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : alt_sum[DIST_W-1:0];
  assign relax_hit = (state == S_RELAX) && p_v && e_rd[WEIGHT_BITS] && !visited[p_i] &&
                     (!reached[p_i] || alt < d_rd);
  assign scan_hit = (state == S_SCAN) && p_v && reached[p_i] && !visited[p_i] &&
                    (!have || d_rd < qdist);

  always_comb begin
    e_we = 1'b0;
    e_wa = clr;
    e_wd = '0;
    if (state == S_CLEAR) begin
      e_we = 1'b1;
    end else if (accept && req.command == CMD_EDGE) begin
      e_we = 1'b1;
      e_wa = {req.from_node, req.to_node};
      e_wd = req.edge_present ? {1'b1, in_w} : '0;
    end
  end

  // distance and predecessor writes: seed the source, or record a relaxation
  always_comb begin
    d_we = 1'b0;
    d_wa = p_i;
    d_wd = alt;
    p_we = 1'b0;
    p_wa = p_i;
    p_wd = {1'b0, q};
    if (accept && req.command == CMD_QUERY && query_ok) begin
      d_we = 1'b1;
      d_wa = req.from_node;
      d_wd = '0;
      p_we = 1'b1;
      p_wa = req.from_node;
      p_wd = NO_PRED;
    end else if (relax_hit) begin
      d_we = 1'b1;
      p_we = 1'b1;
    end
  end

  assign b_we = (state == S_TRD);

  sps_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge (
    .clk(clk), .we(e_we), .wa(e_wa), .wd(e_wd), .ra({q, i[NODE_W-1:0]}), .rd(e_rd)
  );
  sps_ram #(.WIDTH(DIST_W), .DEPTH(SLOTS)) u_dist (
    .clk(clk), .we(d_we), .wa(d_wa), .wd(d_wd), .ra(i[NODE_W-1:0]), .rd(d_rd)
  );
  sps_ram #(.WIDTH(NODE_W + 1), .DEPTH(SLOTS)) u_pred (
    .clk(clk), .we(p_we), .wa(p_wa), .wd(p_wd), .ra(x), .rd(p_rd)
  );
  sps_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_path (
    .clk(clk), .we(b_we), .wa(cnt[NODE_W-1:0]), .wd(x), .ra(idx), .rd(b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      node_count <= CNT_W'(SLOTS);
      rsp.valid  <= 1'b0;
      p_v        <= 1'b0;
      i          <= '0;
      have       <= 1'b0;
      reached    <= '0;
      visited    <= '0;
    end else begin
      if (cfg.valid) begin
        node_count <= cfg.data;
      end
      // hold a waiting result until taken, load the next one when the slot frees
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      // shared index pipeline for the scan and relax sweeps
      if (state == S_SCAN || state == S_RELAX) begin
        if (i < n) begin
          i <= i + 1'b1;
        end
        p_v <= (i < n);
        p_i <= i[NODE_W-1:0];
      end

      if (scan_hit) begin
        have  <= 1'b1;
        q     <= p_i;
        qdist <= d_rd;
      end
      if (relax_hit) begin
        reached[p_i] <= 1'b1;
      end

      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && req.command == CMD_QUERY) begin
            if (query_ok) begin
              reached <= SLOTS'(1) << req.from_node;
              visited <= '0;
              dst     <= req.to_node;
              i       <= '0;
              p_v     <= 1'b0;
              have    <= 1'b0;
              state   <= S_SCAN;
            end else begin
              state <= S_NF;
            end
          end
        end
        S_SCAN: begin
          if (sweep_done) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (!have) begin
            state <= S_NF;
          end else if (q == dst) begin
            res_dist <= qdist;
            x        <= dst;
            cnt      <= '0;
            state    <= S_TRD;
          end else begin
            visited[q] <= 1'b1;
            i          <= '0;
            p_v        <= 1'b0;
            state      <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (sweep_done) begin
            i     <= '0;
            have  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_TRD: begin
          // store x in the path buffer, fetch its predecessor
          cnt   <= cnt + 1'b1;
          state <= S_TWT;
        end
        S_TWT: begin
          if (p_rd[NODE_W] || cnt == CNT_W'(SLOTS)) begin
            idx   <= NODE_W'(cnt - 1'b1);
            state <= S_ERD;
          end else begin
            x     <= p_rd[NODE_W-1:0];
            state <= S_TRD;
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          if (out_free) begin
            rsp.path_node      <= b_rd;
            rsp.path_found     <= 1'b1;
            rsp.total_distance <= res_dist;
            rsp.last           <= (idx == '0);
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_ERD;
            end
          end
        end
        S_NF: begin
          if (out_free) begin
            rsp.path_node      <= '0;
            rsp.path_found     <= 1'b0;
            rsp.total_distance <= '0;
            rsp.last           <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_nf_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.path_found |-> rsp.last)
    else $error("not-found result without last");
  a_relax_visited: assert property (@(posedge clk) disable iff (rst)
    state == S_RELAX |-> visited[q])
    else $error("relaxing from an unsettled node");
  a_pipe_range: assert property (@(posedge clk) disable iff (rst)
    p_v |-> ({1'b0, p_i} < n))
    else $error("sweep index beyond node count");
  a_relax_write: assert property (@(posedge clk) disable iff (rst)
    relax_hit |=> reached[$past(p_i)])
    else $error("relaxed node not marked reached");
endmodule
